[src/gtc_pkg.sv]
// ----------------------------------------------------------------------------
// Gated timer/counter package
// Shared types and constants for the three-mode gated timer/counter: opcodes,
// counting modes, register map and the payload structs of both channels.
// ----------------------------------------------------------------------------
package gtc_pkg;

	// Width of the APB address bus: three word registers at 0x0, 0x4 and 0x8.
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	// Register index, taken from paddr[3:2].
	localparam logic [1:0] REG_TIMER_MODE     = 2'd0;
	localparam logic [1:0] REG_GATE_ENABLE    = 2'd1;
	localparam logic [1:0] REG_COUNT_EXTERNAL = 2'd2;

	// Field masks of the 13-bit mode: low 5 bits count, upper 3 bits are kept.
	localparam logic [7:0] MODE0_LOW_MASK  = 8'h1F;
	localparam logic [7:0] MODE0_KEEP_MASK = 8'hE0;

	// Item opcodes; the fourth code is a no-op that reports the current count.
	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_WRITE_LOW  = 2'd1,
		OP_WRITE_HIGH = 2'd2,
		OP_NOP        = 2'd3
	} opcode_t;

	// Counting modes; the fourth mode is unsupported and flags an error.
	typedef enum logic [1:0] {
		MODE_13BIT       = 2'd0,
		MODE_16BIT       = 2'd1,
		MODE_8BIT_RELOAD = 2'd2,
		MODE_UNSUPPORTED = 2'd3
	} timer_mode_t;

	// Payload of one input item.
	typedef struct packed {
		opcode_t    opcode;
		logic [7:0] write_data;
		logic       run_enable;
		logic       gate_pin;
		logic       external_pulse;
		logic [2:0] machine_cycles;
	} item_t;

	// Payload of one result item.
	typedef struct packed {
		logic [7:0] low_value;
		logic [7:0] high_value;
		logic       overflow;
		logic       mode_error;
	} result_t;

endpackage

[src/gtc_item_if.sv]
// ----------------------------------------------------------------------------
// Item channel
// Valid/ready channel that carries one input item of the timer/counter.
// ----------------------------------------------------------------------------
interface gtc_item_if;

	logic           valid;
	logic           ready;
	gtc_pkg::item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

[src/gtc_result_if.sv]
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one result item of the timer/counter.
// ----------------------------------------------------------------------------
interface gtc_result_if;

	logic             valid;
	logic             ready;
	gtc_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

[src/gated_timer_counter_three_modes.sv]
// ----------------------------------------------------------------------------
// Gated timer/counter with three counting modes
// Accepts tick and byte-write items, updates the two count bytes in one pass
// and returns the count, an overflow pulse and a mode error flag per item.
// ----------------------------------------------------------------------------
// Pipeline: each item passes the input register, then the result register; the
// result register holds its result while result.ready is low.
// Throughput: one item per cycle while results are taken; the count bytes update in
// a single pass of the adders, so the next item sees the new count in the following cycle.
// Reset: arst_n clears the count bytes, the configuration registers and both
// valid flags asynchronously.
module gated_timer_counter_three_modes (
	input  logic                                clk,
	input  logic                                arst_n,
	gtc_item_if.sink                            item,
	gtc_result_if.source                        result,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [gtc_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [gtc_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [gtc_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	// Configuration registers.
	gtc_pkg::timer_mode_t timer_mode_q;
	logic                 gate_enable_q;
	logic                 count_external_q;

	// Count state.
	logic [7:0] count_low_q;
	logic [7:0] count_high_q;

	// Input stage and result stage.
	logic             valid_s1;
	gtc_pkg::item_t   item_s1;
	logic             valid_s2;
	gtc_pkg::result_t result_s2;

	logic advance_s1;
	logic cfg_write;
	logic [1:0] reg_idx;

	// Next-count logic.
	logic       counting;
	logic [2:0] increment;
	logic [13:0] sum13;
	logic [16:0] sum16;
	logic [8:0]  sum8;
	logic [7:0]  next_low;
	logic [7:0]  next_high;
	logic        next_ovf;
	logic        next_err;

	// APB port: always ready, register selected by the word address.
	assign pready    = 1'b1;
	assign reg_idx   = paddr[3:2];
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			gtc_pkg::REG_TIMER_MODE:     prdata[1:0] = timer_mode_q;
			gtc_pkg::REG_GATE_ENABLE:    prdata[0]   = gate_enable_q;
			gtc_pkg::REG_COUNT_EXTERNAL: prdata[0]   = count_external_q;
			default:                     prdata      = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_mode_q     <= gtc_pkg::MODE_13BIT;
			gate_enable_q    <= 1'b0;
			count_external_q <= 1'b0;
		end else if (cfg_write) begin
			unique case (reg_idx)
				gtc_pkg::REG_TIMER_MODE:
					timer_mode_q <= gtc_pkg::timer_mode_t'(pwdata[1:0]);
				gtc_pkg::REG_GATE_ENABLE:    gate_enable_q    <= pwdata[0];
				gtc_pkg::REG_COUNT_EXTERNAL: count_external_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// Flow control: the input stage moves on whenever the result register is
	// free or being taken in this cycle.
	assign advance_s1 = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1 <= item.data;
		end
	end

	// A tick counts while run is on and the gate, if enabled, is open.
	assign counting = (item_s1.opcode == gtc_pkg::OP_TICK) && item_s1.run_enable
		&& (!gate_enable_q || item_s1.gate_pin);
	assign increment = count_external_q ? {2'b00, item_s1.external_pulse}
		: item_s1.machine_cycles;

	assign sum13 = {1'b0, count_high_q, count_low_q[4:0]} + {11'd0, increment};
	assign sum16 = {1'b0, count_high_q, count_low_q} + {14'd0, increment};
	assign sum8  = {1'b0, count_low_q} + {6'd0, increment};

	// Next count, overflow and error for the item in the input stage.
	always_comb begin
		next_low  = count_low_q;
		next_high = count_high_q;
		next_ovf  = 1'b0;
		next_err  = 1'b0;
		case (item_s1.opcode)
			gtc_pkg::OP_WRITE_LOW:  next_low  = item_s1.write_data;
			gtc_pkg::OP_WRITE_HIGH: next_high = item_s1.write_data;
			gtc_pkg::OP_TICK: begin
				if (counting) begin
					unique case (timer_mode_q)
						gtc_pkg::MODE_13BIT: begin
							next_low  = (count_low_q & gtc_pkg::MODE0_KEEP_MASK)
								| ({3'b000, sum13[4:0]} & gtc_pkg::MODE0_LOW_MASK);
							next_high = sum13[12:5];
							next_ovf  = sum13[13];
						end
						gtc_pkg::MODE_16BIT: begin
							next_low  = sum16[7:0];
							next_high = sum16[15:8];
							next_ovf  = sum16[16];
						end
						gtc_pkg::MODE_8BIT_RELOAD: begin
							// On wrap the reload byte is added to the wrapped low byte.
							next_low  = sum8[8] ? (sum8[7:0] + count_high_q) : sum8[7:0];
							next_ovf  = sum8[8];
						end
						gtc_pkg::MODE_UNSUPPORTED: next_err = 1'b1;
						default: next_err = 1'b1;
					endcase
				end
			end
			default: ;
		endcase
	end

	// Count state and result register update together.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_low_q  <= 8'd0;
			count_high_q <= 8'd0;
			valid_s2     <= 1'b0;
		end else begin
			if (advance_s1) begin
				count_low_q  <= next_low;
				count_high_q <= next_high;
			end
			if (!valid_s2 || result.ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			result_s2.low_value  <= next_low;
			result_s2.high_value <= next_high;
			result_s2.overflow   <= next_ovf;
			result_s2.mode_error <= next_err;
		end
	end

	assign result.valid = valid_s2;
	assign result.data  = result_s2;

`ifndef SYNTHESIS
	// The held result always shows the current count.
	a_result_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (result_s2.low_value == count_low_q)
			&& (result_s2.high_value == count_high_q))
		else $error("result count differs from count state");

	// Overflow and mode error never appear together.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(result_s2.overflow && result_s2.mode_error))
		else $error("overflow and mode error both set");

	// A mode error is only reported in the unsupported mode.
	a_error_mode: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && result_s2.mode_error) |->
			(timer_mode_q == gtc_pkg::MODE_UNSUPPORTED))
		else $error("mode error outside the unsupported mode");

	// A low-byte write shows the written byte in its result.
	a_write_low: assert property (@(posedge clk) disable iff (!arst_n)
		(advance_s1 && (item_s1.opcode == gtc_pkg::OP_WRITE_LOW)) |=>
			(result_s2.low_value == $past(item_s1.write_data)))
		else $error("low byte write not reflected in result");

	// With no result pending the block always takes a new item.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> item.ready)
		else $error("input stalled with empty result register");
`endif

endmodule

[tb/gated_timer_counter_three_modes_tb.sv]
// ----------------------------------------------------------------------------
// Gated timer/counter testbench
// Sends tick and byte-write items through the item channel and checks every
// result against a cycle-free model of the count bytes. The run has a short
// directed part for each counting mode, then random phases under changing
// register settings and changing backpressure on both channels.
// ----------------------------------------------------------------------------
module gated_timer_counter_three_modes_tb;

	import gtc_pkg::*;

	localparam int ITEMS_PER_PHASE = 130;
	localparam int RANDOM_PHASES   = 12;
	localparam int MAX_REPORTS     = 40;

	// Clock, reset and configuration port.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// Channel drive registers; they hold known values from time zero.
	logic    item_valid_q = 1'b0;
	item_t   item_data_q = '0;
	logic    result_ready_q = 1'b0;
	logic    item_fire = 1'b0;

	gtc_item_if   item_ch();
	gtc_result_if result_ch();

	assign item_ch.valid   = item_valid_q;
	assign item_ch.data    = item_data_q;
	assign result_ch.ready = result_ready_q;

	gated_timer_counter_three_modes DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Items waiting to be sent and counts waiting to come back.
	item_t   pending_items[$];
	result_t awaited_counts[$];

	// Model of the count bytes and the registers.
	logic [7:0]  count_low_now = '0;
	logic [7:0]  count_high_now = '0;
	timer_mode_t cfg_mode = MODE_13BIT;
	logic        cfg_gate = 1'b0;
	logic        cfg_external = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int error_count = 0;

	// Clock generation.
	initial begin
		forever #5 clk = ~clk;
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic item_t make_item(opcode_t op, logic [7:0] data, logic run,
			logic gate, logic pulse, logic [2:0] cycles);
		item_t it;
		it.opcode         = op;
		it.write_data     = data;
		it.run_enable     = run;
		it.gate_pin       = gate;
		it.external_pulse = pulse;
		it.machine_cycles = cycles;
		return it;
	endfunction

	// Applies one item to the model count and returns the count it reports.
	function automatic result_t advance_counter(item_t it);
		result_t    r;
		logic [3:0] step;
		logic [13:0] sum13;
		logic [16:0] sum16;
		logic [8:0]  sum8;
		r.overflow   = 1'b0;
		r.mode_error = 1'b0;
		case (it.opcode)
			OP_WRITE_LOW: begin
				count_low_now = it.write_data;
			end
			OP_WRITE_HIGH: begin
				count_high_now = it.write_data;
			end
			OP_TICK: begin
				if (it.run_enable && (!cfg_gate || it.gate_pin)) begin
					step = cfg_external ? {3'b000, it.external_pulse} : {1'b0, it.machine_cycles};
					case (cfg_mode)
						MODE_13BIT: begin
							// High byte over the low five bits; the top three low bits stay.
							sum13 = {1'b0, count_high_now, count_low_now[4:0]} + step;
							count_low_now  = (count_low_now & MODE0_KEEP_MASK) |
								({3'b000, sum13[4:0]} & MODE0_LOW_MASK);
							count_high_now = sum13[12:5];
							r.overflow     = sum13[13];
						end
						MODE_16BIT: begin
							sum16 = {1'b0, count_high_now, count_low_now} + step;
							count_low_now  = sum16[7:0];
							count_high_now = sum16[15:8];
							r.overflow     = sum16[16];
						end
						MODE_8BIT_RELOAD: begin
							// On wrap the high byte is added to the wrapped low byte.
							sum8 = {1'b0, count_low_now} + step;
							r.overflow    = sum8[8];
							count_low_now = sum8[8] ? sum8[7:0] + count_high_now : sum8[7:0];
						end
						default: begin
							r.mode_error = 1'b1;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		r.low_value  = count_low_now;
		r.high_value = count_high_now;
		return r;
	endfunction

	// A write of the high byte, a write of the low byte close to the top of the
	// count, then a run of ticks that mostly count; returns the items queued.
	function automatic int queue_count_sequence();
		logic [7:0] high_byte;
		logic [7:0] low_byte;
		int         ticks;
		high_byte = $urandom_range(0, 1) ? 8'hFF : 8'($urandom);
		low_byte  = $urandom_range(0, 1) ?
			({3'($urandom), 5'b11000} | 8'($urandom_range(0, 7))) : 8'($urandom);
		ticks     = $urandom_range(0, 4) == 0 ? $urandom_range(10, 40) : $urandom_range(2, 10);
		pending_items.push_back(make_item(OP_WRITE_HIGH, high_byte, 1'($urandom),
			1'($urandom), 1'($urandom), 3'($urandom)));
		pending_items.push_back(make_item(OP_WRITE_LOW, low_byte, 1'($urandom),
			1'($urandom), 1'($urandom), 3'($urandom)));
		for (int i = 0; i < ticks; i++) begin
			pending_items.push_back(make_item(OP_TICK, 8'($urandom),
				$urandom_range(0, 9) != 0, $urandom_range(0, 5) != 0,
				$urandom_range(0, 3) != 0, 3'($urandom_range(0, 7))));
		end
		return ticks + 2;
	endfunction

	// Any opcode with every field random.
	function automatic item_t random_item();
		return make_item(opcode_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom),
			1'($urandom), 1'($urandom), 3'($urandom));
	endfunction

	// Waits until every queued item has been sent and every count has come back.
	task automatic wait_until_idle();
		while (pending_items.size() != 0 || item_valid_q || awaited_counts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One APB write: setup cycle, then access cycle until pready.
	task automatic write_register(input logic [1:0] index, input logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (index)
			REG_TIMER_MODE:     cfg_mode = timer_mode_t'(value[1:0]);
			REG_GATE_ENABLE:    cfg_gate = value[0];
			REG_COUNT_EXTERNAL: cfg_external = value[0];
			default: begin
			end
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Registers change only once the block has gone quiet.
	task automatic apply_config(input timer_mode_t mode, input logic gate, input logic ext);
		wait_until_idle();
		write_register(REG_TIMER_MODE, 32'(mode));
		write_register(REG_GATE_ENABLE, 32'(gate));
		write_register(REG_COUNT_EXTERNAL, 32'(ext));
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			if (error_count < MAX_REPORTS)
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// Item driver: after each transfer or idle cycle the next item goes out, unless a random idle is drawn.
	always @(negedge clk) begin
		if (!arst_n) begin
			item_valid_q <= 1'b0;
		end else if (!item_valid_q || item_fire) begin
			if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				item_valid_q <= 1'b1;
				item_data_q  <= pending_items.pop_front();
			end else begin
				item_valid_q <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls.
	always @(negedge clk) begin
		result_ready_q <= $urandom_range(0, 99) >= recv_idle_pct;
	end

	// Monitor: checks each result transfer, then predicts each item transfer.
	always @(posedge clk) begin
		result_t want;
		item_fire <= arst_n && item_ch.valid && item_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (awaited_counts.size() == 0) begin
				if (error_count < MAX_REPORTS)
					$display("%0t: unexpected result, expected none, actual %h", $time,
						result_ch.data);
				error_count++;
			end else begin
				want = awaited_counts.pop_front();
				compare_field("low_value", want.low_value, result_ch.data.low_value);
				compare_field("high_value", want.high_value, result_ch.data.high_value);
				compare_field("overflow", want.overflow, result_ch.data.overflow);
				compare_field("mode_error", want.mode_error, result_ch.data.mode_error);
			end
		end
		if (arst_n && item_ch.valid && item_ch.ready)
			awaited_counts.push_back(advance_counter(item_ch.data));
	end

	// Stimulus and run control.
	initial begin
		int sent;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 12;
		recv_idle_pct = 86;

		// 13-bit mode from reset: idle tick, counting ticks, full wrap, no-op.
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1, 3'd7));
		pending_items.push_back(make_item(OP_TICK, 8'hFF, 1'b1, 1'b0, 1'b0, 3'd7));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 3'd0));
		pending_items.push_back(make_item(OP_WRITE_LOW, 8'hFF, 1'b0, 1'b0, 1'b0, 3'd0));
		pending_items.push_back(make_item(OP_WRITE_HIGH, 8'hFF, 1'b1, 1'b1, 1'b1, 3'd7));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 3'd1));
		pending_items.push_back(make_item(OP_NOP, 8'hFF, 1'b1, 1'b1, 1'b1, 3'd7));
		pending_items.push_back(make_item(OP_WRITE_LOW, 8'h00, 1'b1, 1'b1, 1'b1, 3'd7));
		pending_items.push_back(make_item(OP_WRITE_HIGH, 8'h00, 1'b0, 1'b0, 1'b0, 3'd0));

		// 16-bit mode, gated, external pulses: gate low holds, pulse wraps.
		apply_config(MODE_16BIT, 1'b1, 1'b1);
		pending_items.push_back(make_item(OP_WRITE_HIGH, 8'hFF, 1'b0, 1'b0, 1'b0, 3'd0));
		pending_items.push_back(make_item(OP_WRITE_LOW, 8'hFF, 1'b0, 1'b0, 1'b0, 3'd0));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b1, 3'd7));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b1, 1'b0, 3'd7));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b1, 1'b1, 3'd0));

		// 8-bit reload mode: plain reload, then a reload add that wraps again.
		apply_config(MODE_8BIT_RELOAD, 1'b0, 1'b0);
		pending_items.push_back(make_item(OP_WRITE_HIGH, 8'h80, 1'b0, 1'b0, 1'b0, 3'd0));
		pending_items.push_back(make_item(OP_WRITE_LOW, 8'hFE, 1'b0, 1'b0, 1'b0, 3'd0));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 3'd7));
		pending_items.push_back(make_item(OP_WRITE_HIGH, 8'hFF, 1'b0, 1'b0, 1'b0, 3'd0));
		pending_items.push_back(make_item(OP_WRITE_LOW, 8'hFF, 1'b0, 1'b0, 1'b0, 3'd0));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 3'd7));

		// Unsupported mode: only a counting tick flags the error.
		apply_config(MODE_UNSUPPORTED, 1'b1, 1'b0);
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b1, 1'b0, 3'd5));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b1, 1'b0, 1'b0, 3'd5));
		pending_items.push_back(make_item(OP_TICK, 8'h00, 1'b0, 1'b1, 1'b0, 3'd5));
		pending_items.push_back(make_item(OP_WRITE_LOW, 8'h5A, 1'b1, 1'b1, 1'b1, 3'd5));

		// Random phases: backpressure on the receiver, then on the sender, then none.
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			apply_config(timer_mode_t'(p % 4), 1'((p / 2) % 2), 1'((p / 4) % 2));
			send_idle_pct = p < 4 ? 12 : (p < 8 ? 86 : 0);
			recv_idle_pct = p < 4 ? 86 : (p < 8 ? 12 : 0);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				for (int k = 0; k < 4; k++) begin
					if ($urandom_range(0, 9) < 7) begin
						sent += queue_count_sequence();
					end else begin
						pending_items.push_back(random_item());
						sent++;
					end
				end
				while (pending_items.size() != 0) @(posedge clk);
				// Now and then the sender holds off until every count is back.
				if ($urandom_range(0, 3) == 0)
					wait_until_idle();
			end
		end

		wait_until_idle();
		repeat (8) @(posedge clk);
		if (error_count == 0 && awaited_counts.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
